// ===== design/aoc_pkg.sv =====
// ----------------------------------------------------------------------------
// Alpha-over compositor package
// Payload types for the pixel and result channels, register indexes and the
// per-stage pipeline record shared by the compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package aoc_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_LAYER_OPACITY = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_ENABLE   = 8'd1;

   localparam logic [7:0] OPAQUE_LEVEL = 8'd255;

   typedef struct packed {
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_opacity;
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_opacity;
      logic [7:0] mask_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_opacity;
   } rsp_type;

   // Everything one pixel carries down the pipeline. Fields that a stage
   // has no use for yet simply ride along.
   typedef struct packed {
      req_type            pix;
      logic [7:0]         alpha;
      logic               zero;
      logic [7:0]         new_alpha;
      logic [7:0]         num_low;
      logic [7:0]         rem;
      logic [7:0]         quo;
      logic               sat;
      logic               copy;
      logic signed [17:0] prod_red;
      logic signed [17:0] prod_green;
      logic signed [17:0] prod_blue;
      rsp_type            result;
   } stage_type;

endpackage

`default_nettype wire

// ===== design/alpha_over_compositor_unit.sv =====
// ----------------------------------------------------------------------------
// Alpha-over compositor unit
// Composites one 8-bit RGBA source pixel over a destination pixel, with an
// optional mask byte and a global layer opacity, in a ten-stage pipeline.
// ----------------------------------------------------------------------------
// rsp_valid rises once an accepted request has passed the stage registers ST_MASK to ST_OUT.
// Throughput: one pixel per cycle while rsp_ready is high; no feedback between pixels.
// The blend-factor divide is a restoring divider, two quotient bits per stage
// over four stages; the multiplies and that divider set the stage count.
// Reset clears all stage valid bits, sets layer_opacity to 255 and mask_enable
// to 0.
`default_nettype none

module alpha_over_compositor_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  aoc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output aoc_pkg::rsp_type                   rsp_data,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [aoc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [aoc_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int ST_MASK     = 0;
   localparam int ST_OPACITY  = 1;
   localparam int ST_NEWALPHA = 2;
   localparam int ST_DIVSETUP = 3;
   localparam int ST_DIV0     = 4;
   localparam int ST_DIV3     = 7;
   localparam int ST_BLEND    = 8;
   localparam int ST_OUT      = 9;
   localparam int NUM_STAGES  = 10;

   // ------------------------------------------------------------------------
   // Arithmetic helpers
   // ------------------------------------------------------------------------
   function automatic logic [7:0] umult8(input logic [7:0] a, input logic [7:0] b);
      logic [16:0] t;
      logic [16:0] s;
      t = a * b + 17'd128;
      s = t + (t >> 8);
      return s[15:8];
   endfunction

   // One restoring-division step: returns the quotient bit and new remainder.
   function automatic logic [8:0] div_step(input logic [7:0] rem,
                                           input logic       bit_in,
                                           input logic [7:0] divisor);
      logic [8:0] shifted;
      logic [8:0] diff;
      shifted = {rem, bit_in};
      diff    = shifted - {1'b0, divisor};
      if (shifted >= {1'b0, divisor}) begin
         return {1'b1, diff[7:0]};
      end
      return {1'b0, shifted[7:0]};
   endfunction

   function automatic logic signed [17:0] blend_term(input logic [7:0] s,
                                                     input logic [7:0] d,
                                                     input logic [7:0] f);
      logic signed [8:0]  diff;
      logic signed [17:0] prod;
      diff = $signed({1'b0, s}) - $signed({1'b0, d});
      prod = diff * $signed({1'b0, f});
      return prod + 18'sd128;
   endfunction

   // Finishes mult(s-d, f) with flooring shifts and adds it to d.
   function automatic logic [7:0] blend_finish(input logic signed [17:0] t,
                                               input logic [7:0]         d);
      logic signed [17:0] t2;
      logic signed [17:0] r;
      t2 = t + (t >>> 8);
      r  = t2 >>> 8;
      return d + r[7:0];
   endfunction

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [7:0] layer_opacity_ff;
   logic       mask_enable_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_opacity_ff <= aoc_pkg::OPAQUE_LEVEL;
         mask_enable_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            aoc_pkg::CSR_LAYER_OPACITY: layer_opacity_ff <= csr_data[7:0];
            aoc_pkg::CSR_MASK_ENABLE:   mask_enable_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline flow control: a stage loads when it is empty or its item moves on.
   // ------------------------------------------------------------------------
   logic                    valid_ff [NUM_STAGES];
   aoc_pkg::stage_type      data_ff  [NUM_STAGES];
   aoc_pkg::stage_type      data_in  [NUM_STAGES];
   logic                    valid_in [NUM_STAGES];
   logic [NUM_STAGES:0]     stage_ready;

   always_comb begin
      stage_ready[NUM_STAGES] = rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[ST_OUT];
   assign rsp_data  = data_ff[ST_OUT].result;

   // ------------------------------------------------------------------------
   // Stage datapath
   // ------------------------------------------------------------------------
   always_comb begin
      aoc_pkg::stage_type prev;
      aoc_pkg::stage_type nxt;
      logic [15:0]        num;
      logic [8:0]         step_hi;
      logic [8:0]         step_lo;
      logic [7:0]         factor;
      logic               keep_dst_alpha;
      logic [7:0]         blend_red;
      logic [7:0]         blend_green;
      logic [7:0]         blend_blue;

      for (int k = 0; k < NUM_STAGES; k++) begin
         prev     = (k == 0) ? '0 : data_ff[(k == 0) ? 0 : k-1];
         prev.pix = (k == 0) ? req_data : prev.pix;
         nxt      = prev;
         num      = '0;
         step_hi  = '0;
         step_lo  = '0;
         factor   = '0;
         keep_dst_alpha = 1'b0;
         blend_red      = '0;
         blend_green    = '0;
         blend_blue     = '0;

         case (k)
            ST_MASK: begin
               if (mask_enable_ff && prev.pix.mask_value != aoc_pkg::OPAQUE_LEVEL) begin
                  nxt.alpha = umult8(prev.pix.src_opacity, prev.pix.mask_value);
               end else begin
                  nxt.alpha = prev.pix.src_opacity;
               end
            end
            ST_OPACITY: begin
               nxt.zero = (prev.alpha == 8'd0);
               if (layer_opacity_ff != aoc_pkg::OPAQUE_LEVEL) begin
                  nxt.alpha = umult8(prev.alpha, layer_opacity_ff);
               end
            end
            ST_NEWALPHA: begin
               nxt.new_alpha = prev.pix.dst_opacity
                             + umult8(aoc_pkg::OPAQUE_LEVEL - prev.pix.dst_opacity,
                                      prev.alpha);
            end
            ST_DIVSETUP: begin
               // Rounded numerator alpha*255 + new_alpha/2. A quotient that would
               // not fit in eight bits shows up as a high byte >= the divisor.
               num = {prev.alpha, 8'd0} - {8'd0, prev.alpha}
                   + {9'd0, prev.new_alpha[7:1]};
               nxt.rem     = num[15:8];
               nxt.num_low = num[7:0];
               nxt.sat     = (num[15:8] >= prev.new_alpha);
               nxt.quo     = '0;
            end
            ST_BLEND: begin
               if (prev.pix.dst_opacity == aoc_pkg::OPAQUE_LEVEL
                   || prev.new_alpha == 8'd0) begin
                  factor = prev.alpha;
               end else if (prev.sat) begin
                  factor = aoc_pkg::OPAQUE_LEVEL;
               end else begin
                  factor = prev.quo;
               end
               nxt.copy = (prev.alpha == aoc_pkg::OPAQUE_LEVEL)
                        || (factor == aoc_pkg::OPAQUE_LEVEL);
               nxt.prod_red   = blend_term(prev.pix.src_red,   prev.pix.dst_red,   factor);
               nxt.prod_green = blend_term(prev.pix.src_green, prev.pix.dst_green, factor);
               nxt.prod_blue  = blend_term(prev.pix.src_blue,  prev.pix.dst_blue,  factor);
            end
            ST_OUT: begin
               blend_red   = blend_finish(prev.prod_red,   prev.pix.dst_red);
               blend_green = blend_finish(prev.prod_green, prev.pix.dst_green);
               blend_blue  = blend_finish(prev.prod_blue,  prev.pix.dst_blue);
               keep_dst_alpha = prev.zero
                              || (prev.alpha == aoc_pkg::OPAQUE_LEVEL)
                              || (prev.pix.dst_opacity == aoc_pkg::OPAQUE_LEVEL);
               if (prev.zero) begin
                  nxt.result.out_red   = prev.pix.dst_red;
                  nxt.result.out_green = prev.pix.dst_green;
                  nxt.result.out_blue  = prev.pix.dst_blue;
               end else if (prev.copy) begin
                  nxt.result.out_red   = prev.pix.src_red;
                  nxt.result.out_green = prev.pix.src_green;
                  nxt.result.out_blue  = prev.pix.src_blue;
               end else begin
                  nxt.result.out_red   = blend_red;
                  nxt.result.out_green = blend_green;
                  nxt.result.out_blue  = blend_blue;
               end
               nxt.result.out_opacity = keep_dst_alpha ? prev.pix.dst_opacity
                                                       : prev.new_alpha;
            end
            default: begin
               // Divider stages: two quotient bits each, numerator bits taken
               // from the top of num_low, which shifts left as they are used.
               step_hi     = div_step(prev.rem, prev.num_low[7], prev.new_alpha);
               step_lo     = div_step(step_hi[7:0], prev.num_low[6], prev.new_alpha);
               nxt.rem     = step_lo[7:0];
               nxt.quo     = {prev.quo[5:0], step_hi[8], step_lo[8]};
               nxt.num_low = {prev.num_low[5:0], 2'b00};
            end
         endcase

         data_in[k] = nxt;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (stage_ready[k]) begin
            valid_ff[k] <= valid_in[k];
         end
         if (stage_ready[k]) begin
            data_ff[k] <= data_in[k];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // With every stage full and the output stalled, no request may be taken.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_OUT] && !rsp_ready && valid_ff[ST_MASK] && valid_ff[ST_OPACITY]
       && valid_ff[ST_NEWALPHA] && valid_ff[ST_DIVSETUP] && valid_ff[ST_DIV0]
       && valid_ff[5] && valid_ff[6] && valid_ff[ST_DIV3] && valid_ff[ST_BLEND])
      |-> !req_ready)
      else $error("request accepted into a full, stalled pipeline");

   // The divider remainder stays below the divisor when no saturation occurred.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_DIV3] && !data_ff[ST_DIV3].sat)
      |-> (data_ff[ST_DIV3].rem < data_ff[ST_DIV3].new_alpha))
      else $error("divider remainder out of range");

   // An item in the blend stage held by a stall must still be there next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_BLEND] && !stage_ready[ST_OUT])
      |=> (valid_ff[ST_BLEND] && $stable(data_ff[ST_BLEND].prod_red)))
      else $error("stalled blend stage lost its item");

   // An opaque destination always stays opaque.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && data_ff[ST_OUT].pix.dst_opacity == aoc_pkg::OPAQUE_LEVEL)
      |-> (rsp_data.out_opacity == aoc_pkg::OPAQUE_LEVEL))
      else $error("opaque destination lost opacity");

endmodule

`default_nettype wire
